// ----- rtl/bopl_pkg.sv -----
// Shared types, constants and constant functions of the best-offset prefetch learner.
package bopl_pkg;

  localparam int OFFSET_LOW_DEF   = 1;
  localparam int OFFSET_HIGH_DEF  = 256;
  localparam int PRIME_LIMIT_DEF  = 5;
  localparam int OFFSET_COUNT_DEF = 51;
  localparam int LINE_SHIFT_DEF   = 6;
  localparam int ADDR_BITS_DEF    = 48;

  localparam int LINE_W     = 42;
  localparam int OFF_W      = 9;
  localparam int SCORE_W    = 8;
  localparam int ROUNDS_W   = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;
  localparam int RR_DEPTH   = 256;
  localparam int SLOT_W     = 8;

  localparam logic [SCORE_W-1:0]    SCORE_SAT  = 8'hFF;
  localparam logic [ROUNDS_W-1:0]   ROUNDS_MAX = 8'hFF;
  localparam logic [CFG_DATA_W-1:0] SCORE_LIMIT_RST = 8'd31;
  localparam logic [CFG_DATA_W-1:0] ROUND_LIMIT_RST = 8'd100;
  localparam logic [CFG_DATA_W-1:0] BAD_SCORE_RST   = 8'd1;

  typedef enum logic {
    ACT_TRAIN = 1'b0,
    ACT_FILL  = 1'b1
  } action_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SCORE_LIMIT = 2'd0,
    REG_ROUND_LIMIT = 2'd1,
    REG_BAD_SCORE   = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [CFG_DATA_W-1:0] score_limit;
    logic [CFG_DATA_W-1:0] round_limit;
    logic [CFG_DATA_W-1:0] bad_score;
  } cfg_regs_t;

  typedef struct packed {
    logic wr;
    logic clr;
  } score_ctl_t;

  // True when n > 1 and every prime factor of n is at most plim; only primes up to 13 are divided out.
  function automatic logic is_smooth(int n, int plim);
    int r;
    r = n;
    if (plim >= 2) for (int i = 0; i < 8; i++) if (r % 2 == 0) r = r / 2;
    if (plim >= 3) for (int i = 0; i < 6; i++) if (r % 3 == 0) r = r / 3;
    if (plim >= 5) for (int i = 0; i < 4; i++) if (r % 5 == 0) r = r / 5;
    if (plim >= 7) for (int i = 0; i < 3; i++) if (r % 7 == 0) r = r / 7;
    if (plim >= 11) for (int i = 0; i < 3; i++) if (r % 11 == 0) r = r / 11;
    if (plim >= 13) for (int i = 0; i < 3; i++) if (r % 13 == 0) r = r / 13;
    return (n > 1) && (r == 1);
  endfunction

  // The k-th candidate offset in ascending order, or zero when there are too few.
  function automatic logic [OFF_W-1:0] cand_offset(int k, int low, int high, int plim);
    int cnt;
    logic [OFF_W-1:0] res;
    cnt = 0;
    res = '0;
    for (int n = 1; n <= 256; n++) begin
      if (n >= low && n <= high && is_smooth(n, plim)) begin
        if (cnt == k) res = OFF_W'(n);
        cnt++;
      end
    end
    return res;
  endfunction

endpackage

// ----- rtl/bopl_rr_table.sv -----
// Recent-request table: 256-entry direct-mapped memory with per-entry valid bits.
module bopl_rr_table import bopl_pkg::*; #(
  parameter int ADDR_BITS = ADDR_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 rd_en,
  input  logic [ADDR_BITS-1:0] rd_key,
  input  logic                 wr_en,
  input  logic [ADDR_BITS-1:0] wr_key,
  output logic [ADDR_BITS-1:0] rd_word
);

  logic [ADDR_BITS-1:0] mem [RR_DEPTH];
  logic [RR_DEPTH-1:0]  vld;
  logic [SLOT_W-1:0]    rd_idx;
  logic [SLOT_W-1:0]    wr_idx;
  logic [ADDR_BITS-1:0] rd_q;
  logic                 rd_vld_q;

  assign rd_idx = rd_key[7:0] ^ rd_key[15:8];
  assign wr_idx = wr_key[7:0] ^ wr_key[15:8];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (wr_en) begin
      vld[wr_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_key;
    end
  end

  // A write in the same cycle is forwarded so the read sees it.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (wr_en && (wr_idx == rd_idx)) begin
        rd_q     <= wr_key;
        rd_vld_q <= 1'b1;
      end else begin
        rd_q     <= mem[rd_idx];
        rd_vld_q <= vld[rd_idx];
      end
    end
  end

  assign rd_word = rd_vld_q ? rd_q : '0;

endmodule

// ----- rtl/bopl_score_table.sv -----
// Offset score memory with per-entry valid bits that clear at the end of a phase.
module bopl_score_table import bopl_pkg::*; #(
  parameter int DEPTH = OFFSET_COUNT_DEF,
  parameter int IDX_W = 6
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               rd_en,
  input  logic [IDX_W-1:0]   rd_idx,
  input  score_ctl_t         ctl,
  input  logic [IDX_W-1:0]   wr_idx,
  input  logic [SCORE_W-1:0] wr_data,
  output logic [SCORE_W-1:0] rd_score
);

  logic [SCORE_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]   vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (ctl.clr) begin
      vld <= '0;
    end else if (ctl.wr) begin
      vld[wr_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.wr) begin
      mem[wr_idx] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (ctl.clr) begin
        rd_score <= '0;
      end else if (ctl.wr && (wr_idx == rd_idx)) begin
        rd_score <= wr_data;
      end else if (vld[rd_idx]) begin
        rd_score <= mem[rd_idx];
      end else begin
        rd_score <= '0;
      end
    end
  end

endmodule

// ----- rtl/bopl_learner.sv -----
// Scoring, phase control and prefetch result register of the best-offset learner.
module bopl_learner import bopl_pkg::*; #(
  parameter int OFFSET_LOW   = OFFSET_LOW_DEF,
  parameter int OFFSET_HIGH  = OFFSET_HIGH_DEF,
  parameter int PRIME_LIMIT  = PRIME_LIMIT_DEF,
  parameter int OFFSET_COUNT = OFFSET_COUNT_DEF,
  parameter int LINE_SHIFT   = LINE_SHIFT_DEF,
  parameter int ADDR_BITS    = ADDR_BITS_DEF,
  parameter int IDX_W        = 6
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s1_valid,
  input  action_t              s1_action,
  input  logic [ADDR_BITS-1:0] s1_addr,
  input  logic [ADDR_BITS-1:0] s1_key,
  input  logic [ADDR_BITS-1:0] rr_word,
  input  logic [SCORE_W-1:0]   score_rd,
  input  cfg_regs_t            cfg,
  output logic [IDX_W-1:0]     rp_next,
  output logic [OFF_W-1:0]     train_offset,
  output logic                 rr_wr_en,
  output logic [ADDR_BITS-1:0] rr_wr_key,
  output score_ctl_t           score_ctl,
  output logic [IDX_W-1:0]     score_wr_idx,
  output logic [SCORE_W-1:0]   score_wr_data,
  output logic                 result_valid,
  output logic [LINE_W-1:0]    prefetch_line,
  output logic [OFF_W-1:0]     offset_used
);

  logic [OFF_W-1:0] cand [OFFSET_COUNT];

  for (genvar g = 0; g < OFFSET_COUNT; g++) begin : g_cand
    assign cand[g] = cand_offset(g, OFFSET_LOW, OFFSET_HIGH, PRIME_LIMIT);
  end

  logic [IDX_W-1:0]    rp;
  logic [ROUNDS_W-1:0] rounds;
  logic [IDX_W-1:0]    best;
  logic [SCORE_W-1:0]  best_score;
  logic [OFF_W-1:0]    current_offset;
  logic                prefetch_on;

  logic                is_train;
  logic                is_fill;
  logic                hit;
  logic                same;
  logic                beats;
  logic                wrap;
  logic                end_ph;
  logic                on_next;
  logic [SCORE_W-1:0]  new_score;
  logic [SCORE_W-1:0]  top_score;
  logic [IDX_W-1:0]    best_next;
  logic [IDX_W-1:0]    rp_adv;
  logic [ROUNDS_W-1:0] rounds_adv;
  logic [OFF_W-1:0]    offset_next;
  logic [ADDR_BITS-1:0] sum_cur;
  logic [ADDR_BITS-1:0] sum_rp;
  logic [ADDR_BITS-1:0] sum_best;
  logic [ADDR_BITS-1:0] sum_sel;
  logic [ADDR_BITS-1:0] sum_shifted;
  logic [LINE_W+ADDR_BITS-1:0] line_ext;

  assign sum_cur  = s1_addr + ADDR_BITS'(current_offset);
  assign sum_rp   = s1_addr + ADDR_BITS'(cand[rp]);
  assign sum_best = s1_addr + ADDR_BITS'(cand[best]);

  always_comb begin
    is_train   = s1_valid && (s1_action == ACT_TRAIN);
    is_fill    = s1_valid && (s1_action == ACT_FILL);
    hit        = (rr_word == s1_key);
    new_score  = (hit && (score_rd != SCORE_SAT)) ? score_rd + SCORE_W'(1) : score_rd;
    same       = (rp == best);
    beats      = hit && !same && (new_score > best_score);
    best_next  = beats ? rp : best;
    top_score  = (beats || same) ? new_score : best_score;
    wrap       = (rp == IDX_W'(OFFSET_COUNT - 1));
    rp_adv     = wrap ? '0 : rp + IDX_W'(1);
    rounds_adv = (wrap && (rounds != ROUNDS_MAX)) ? rounds + ROUNDS_W'(1) : rounds;
    end_ph     = (rounds_adv >= cfg.round_limit) || (top_score >= cfg.score_limit);
    on_next    = end_ph ? (top_score > cfg.bad_score) : prefetch_on;
    if (!end_ph) begin
      offset_next = current_offset;
      sum_sel     = sum_cur;
    end else if (beats) begin
      offset_next = cand[rp];
      sum_sel     = sum_rp;
    end else begin
      offset_next = cand[best];
      sum_sel     = sum_best;
    end
  end

  assign sum_shifted = sum_sel >> LINE_SHIFT;
  assign line_ext    = {{LINE_W{1'b0}}, sum_shifted};

  assign rp_next       = is_train ? rp_adv : rp;
  assign train_offset  = cand[rp_next];
  assign rr_wr_en      = is_fill && prefetch_on;
  assign rr_wr_key     = s1_addr - ADDR_BITS'(current_offset);
  assign score_ctl.wr  = is_train;
  assign score_ctl.clr = is_train && end_ph;
  assign score_wr_idx  = rp;
  assign score_wr_data = new_score;

  always_ff @(posedge clk) begin
    if (rst) begin
      rp             <= '0;
      rounds         <= '0;
      best           <= '0;
      best_score     <= '0;
      current_offset <= '0;
      prefetch_on    <= 1'b1;
    end else if (is_train) begin
      rp             <= rp_adv;
      rounds         <= end_ph ? '0 : rounds_adv;
      best           <= best_next;
      best_score     <= end_ph ? '0 : top_score;
      current_offset <= offset_next;
      prefetch_on    <= on_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= is_train && on_next;
    end
  end

  always_ff @(posedge clk) begin
    if (is_train && on_next) begin
      prefetch_line <= line_ext[LINE_W-1:0];
      offset_used   <= offset_next;
    end
  end

  a_rp_range: assert property (@(posedge clk) disable iff (rst)
    (rp <= IDX_W'(OFFSET_COUNT - 1)) && (best <= IDX_W'(OFFSET_COUNT - 1)))
    else $error("round position or best index out of range");

  a_result_from_train: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(is_train))
    else $error("result without a training transaction");

  a_offset_matches: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (offset_used == current_offset))
    else $error("result offset differs from the applied offset");

  a_phase_clear: assert property (@(posedge clk) disable iff (rst)
    (is_train && end_ph) |=> ((rounds == '0) && (best_score == '0)))
    else $error("phase end did not clear rounds and best score");

  a_fill_no_state: assert property (@(posedge clk) disable iff (rst)
    (is_fill && !$past(rst)) |=> $stable(rp) && $stable(best))
    else $error("fill transaction changed learner state");

endmodule

// ----- rtl/best_offset_prefetch_learner.sv -----
// Top level of the best-offset prefetch learner: input stage, configuration and tables.
//
// The block takes one transaction per clock cycle: busy never rises, so start is accepted on
// every cycle. A training access produces its prefetch, if prefetching is on, with result_valid
// high for exactly one cycle: the table reads are registered together with the input at
// acceptance, and scoring feeds the result register at the next edge; a fill produces no result.
// The receiver cannot stall the result port. The recent-request table is a 256-entry memory
// read at acceptance of a training access and written from the registered input stage by a fill
// while prefetching is on, with forwarding; its entries read as zero until written, tracked by
// valid bits that reset clears at once, so no clearing pass follows reset. Configuration registers
// should be written only while no transaction is in flight.
module best_offset_prefetch_learner import bopl_pkg::*; #(
  parameter int OFFSET_LOW   = OFFSET_LOW_DEF,
  parameter int OFFSET_HIGH  = OFFSET_HIGH_DEF,
  parameter int PRIME_LIMIT  = PRIME_LIMIT_DEF,
  parameter int OFFSET_COUNT = OFFSET_COUNT_DEF,
  parameter int LINE_SHIFT   = LINE_SHIFT_DEF,
  parameter int ADDR_BITS    = ADDR_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic                  action,
  input  logic [ADDR_BITS-1:0]  access_addr,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output logic                  result_valid,
  output logic [LINE_W-1:0]     prefetch_line,
  output logic [OFF_W-1:0]      offset_used
);

  localparam int IDX_W = (OFFSET_COUNT > 1) ? $clog2(OFFSET_COUNT) : 1;

  logic                 accept;
  logic                 rd_en;
  logic                 s1_valid;
  action_t              s1_action;
  logic [ADDR_BITS-1:0] s1_addr;
  logic [ADDR_BITS-1:0] s1_key;
  logic [ADDR_BITS-1:0] train_key;
  logic [IDX_W-1:0]     rp_next;
  logic [OFF_W-1:0]     train_offset;
  logic                 rr_wr_en;
  logic [ADDR_BITS-1:0] rr_wr_key;
  logic [ADDR_BITS-1:0] rr_word;
  score_ctl_t           score_ctl;
  logic [IDX_W-1:0]     score_wr_idx;
  logic [SCORE_W-1:0]   score_wr_data;
  logic [SCORE_W-1:0]   score_rd;
  cfg_regs_t            cfg;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;
  assign rd_en     = accept && (action_t'(action) == ACT_TRAIN);
  assign train_key = access_addr - ADDR_BITS'(train_offset);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.score_limit <= SCORE_LIMIT_RST;
      cfg.round_limit <= ROUND_LIMIT_RST;
      cfg.bad_score   <= BAD_SCORE_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_SCORE_LIMIT: cfg.score_limit <= cfg_data;
        REG_ROUND_LIMIT: cfg.round_limit <= cfg_data;
        REG_BAD_SCORE:   cfg.bad_score   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_action <= action_t'(action);
      s1_addr   <= access_addr;
      s1_key    <= train_key;
    end
  end

  bopl_rr_table #(
    .ADDR_BITS (ADDR_BITS)
  ) u_rr_table (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (rd_en),
    .rd_key  (train_key),
    .wr_en   (rr_wr_en),
    .wr_key  (rr_wr_key),
    .rd_word (rr_word)
  );

  bopl_score_table #(
    .DEPTH (OFFSET_COUNT),
    .IDX_W (IDX_W)
  ) u_score_table (
    .clk      (clk),
    .rst      (rst),
    .rd_en    (rd_en),
    .rd_idx   (rp_next),
    .ctl      (score_ctl),
    .wr_idx   (score_wr_idx),
    .wr_data  (score_wr_data),
    .rd_score (score_rd)
  );

  bopl_learner #(
    .OFFSET_LOW   (OFFSET_LOW),
    .OFFSET_HIGH  (OFFSET_HIGH),
    .PRIME_LIMIT  (PRIME_LIMIT),
    .OFFSET_COUNT (OFFSET_COUNT),
    .LINE_SHIFT   (LINE_SHIFT),
    .ADDR_BITS    (ADDR_BITS),
    .IDX_W        (IDX_W)
  ) u_learner (
    .clk           (clk),
    .rst           (rst),
    .s1_valid      (s1_valid),
    .s1_action     (s1_action),
    .s1_addr       (s1_addr),
    .s1_key        (s1_key),
    .rr_word       (rr_word),
    .score_rd      (score_rd),
    .cfg           (cfg),
    .rp_next       (rp_next),
    .train_offset  (train_offset),
    .rr_wr_en      (rr_wr_en),
    .rr_wr_key     (rr_wr_key),
    .score_ctl     (score_ctl),
    .score_wr_idx  (score_wr_idx),
    .score_wr_data (score_wr_data),
    .result_valid  (result_valid),
    .prefetch_line (prefetch_line),
    .offset_used   (offset_used)
  );

endmodule

// ----- tb/bopl_prefetch_checker.sv -----
`timescale 1ns / 1ps
// Checker for the best-offset prefetch learner: tracks the learner state and checks each prefetch.
module bopl_prefetch_checker import bopl_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic                     busy,
  input  logic                     action,
  input  logic [ADDR_BITS_DEF-1:0] access_addr,
  input  logic                     cfg_valid,
  input  logic                     cfg_ready,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_DATA_W-1:0]    cfg_data,
  input  logic                     result_valid,
  input  logic [LINE_W-1:0]        prefetch_line,
  input  logic [OFF_W-1:0]         offset_used,
  output int                       errors,
  output int                       pending,
  output logic [OFF_W-1:0]         applied_offset,
  output logic [OFF_W-1:0]         next_candidate,
  output logic                     prefetching
);

  localparam int AW    = ADDR_BITS_DEF;
  localparam int NCAND = OFFSET_COUNT_DEF;

  typedef struct packed {
    logic [LINE_W-1:0] line;
    logic [OFF_W-1:0]  offset;
  } prefetch_t;

  prefetch_t             prefetch_q[$];
  logic [AW-1:0]         recent_lines[RR_DEPTH];
  logic [SCORE_W-1:0]    hit_scores[NCAND];
  logic [OFF_W-1:0]      cand_offsets[NCAND];
  int                    round_pos;
  int                    rounds;
  int                    best;
  logic [OFF_W-1:0]      cur_offset;
  logic                  enabled;
  logic [CFG_DATA_W-1:0] lim_score;
  logic [CFG_DATA_W-1:0] lim_round;
  logic [CFG_DATA_W-1:0] off_score;

  function automatic bit smooth(int n);
    int rest;
    rest = n;
    if (n <= 1) return 1'b0;
    for (int p = 2; p <= rest; p++) begin
      if (rest % p == 0) begin
        if (p > PRIME_LIMIT_DEF) return 1'b0;
        while (rest % p == 0) rest = rest / p;
      end
    end
    return 1'b1;
  endfunction

  function automatic int slot_of(logic [AW-1:0] a);
    return int'(a[7:0] ^ a[15:8]);
  endfunction

  initial begin
    int k;
    k = 0;
    for (int i = 0; i < NCAND; i++) cand_offsets[i] = '0;
    for (int n = OFFSET_LOW_DEF; n <= OFFSET_HIGH_DEF; n++) begin
      if (k < NCAND && smooth(n)) begin
        cand_offsets[k] = OFF_W'(n);
        k++;
      end
    end
  end

  task automatic flag(string what, logic [63:0] want, logic [63:0] got);
    errors++;
    if (errors <= 10) begin
      $display("%0t: %s mismatch: expected %0h, got %0h", $time, what, want, got);
    end
  endtask

  task automatic learn(action_t act, logic [AW-1:0] addr);
    logic [AW-1:0] key;
    logic [AW-1:0] target;
    prefetch_t     item;
    if (act == ACT_FILL) begin
      if (enabled) begin
        key = addr - AW'(cur_offset);
        recent_lines[slot_of(key)] = key;
      end
      return;
    end
    key = addr - AW'(cand_offsets[round_pos]);
    if (recent_lines[slot_of(key)] == key) begin
      if (hit_scores[round_pos] != SCORE_SAT) hit_scores[round_pos]++;
      if (hit_scores[round_pos] > hit_scores[best]) best = round_pos;
    end
    round_pos++;
    if (round_pos == NCAND) begin
      round_pos = 0;
      if (rounds < int'(ROUNDS_MAX)) rounds++;
    end
    if (rounds >= int'(lim_round) || hit_scores[best] >= lim_score) begin
      cur_offset = cand_offsets[best];
      rounds = 0;
      enabled = hit_scores[best] > off_score;
      for (int i = 0; i < NCAND; i++) hit_scores[i] = '0;
    end
    if (enabled) begin
      target = addr + AW'(cur_offset);
      item.line = LINE_W'(target >> LINE_SHIFT_DEF);
      item.offset = cur_offset;
      prefetch_q.push_back(item);
    end
  endtask

  always @(posedge clk) begin
    prefetch_t want;
    if (rst) begin
      prefetch_q.delete();
      for (int i = 0; i < RR_DEPTH; i++) recent_lines[i] = '0;
      for (int i = 0; i < NCAND; i++) hit_scores[i] = '0;
      round_pos = 0;
      rounds = 0;
      best = 0;
      cur_offset = '0;
      enabled = 1'b1;
      lim_score = SCORE_LIMIT_RST;
      lim_round = ROUND_LIMIT_RST;
      off_score = BAD_SCORE_RST;
    end else begin
      if (result_valid) begin
        if (prefetch_q.size() == 0) begin
          flag("unexpected prefetch, line", '0, 64'(prefetch_line));
        end else begin
          want = prefetch_q.pop_front();
          if (prefetch_line !== want.line) begin
            flag("prefetch_line", 64'(want.line), 64'(prefetch_line));
          end
          if (offset_used !== want.offset) begin
            flag("offset_used", 64'(want.offset), 64'(offset_used));
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_SCORE_LIMIT: lim_score = cfg_data;
          REG_ROUND_LIMIT: lim_round = cfg_data;
          REG_BAD_SCORE:   off_score = cfg_data;
          default: ;
        endcase
      end
      if (start && !busy) learn(action_t'(action), access_addr);
    end
    pending = prefetch_q.size();
    applied_offset = cur_offset;
    next_candidate = cand_offsets[round_pos];
    prefetching = enabled;
  end

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// Testbench top for the best-offset prefetch learner: reset, stimulus phases and the verdict.
module testbench;
  import bopl_pkg::*;

  localparam int AW = ADDR_BITS_DEF;

  logic                  clk;
  logic                  rst;
  logic                  start;
  logic                  busy;
  logic                  action;
  logic [AW-1:0]         access_addr;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  result_valid;
  logic [LINE_W-1:0]     prefetch_line;
  logic [OFF_W-1:0]      offset_used;
  logic [OFF_W-1:0]      applied_offset;
  logic [OFF_W-1:0]      next_candidate;
  logic                  prefetching;
  int                    errors;
  int                    pending;
  logic [AW-1:0]         fill_keys[16];
  int                    key_count;
  bit                    gaps_on;

  best_offset_prefetch_learner dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .action(action),
    .access_addr(access_addr), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data), .result_valid(result_valid),
    .prefetch_line(prefetch_line), .offset_used(offset_used)
  );

  bopl_prefetch_checker chk (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .action(action),
    .access_addr(access_addr), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data), .result_valid(result_valid),
    .prefetch_line(prefetch_line), .offset_used(offset_used), .errors(errors),
    .pending(pending), .applied_offset(applied_offset),
    .next_candidate(next_candidate), .prefetching(prefetching)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

  function automatic logic [AW-1:0] rand_addr();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return AW'($urandom_range(0, 600));
      default: return AW'({$urandom, $urandom});
    endcase
  endfunction

  function automatic logic [AW-1:0] recent_key();
    int held;
    held = (key_count < 16) ? key_count : 16;
    if ($urandom_range(0, 1)) return fill_keys[(key_count - 1) % 16];
    return fill_keys[$urandom_range(0, held - 1)];
  endfunction

  // Called at a falling edge; holds the transaction until it is accepted.
  task automatic send(action_t act, logic [AW-1:0] addr);
    start <= 1'b1;
    action <= act;
    access_addr <= addr;
    do @(posedge clk); while (busy);
  endtask

  task automatic fill(logic [AW-1:0] addr);
    if (prefetching) begin
      fill_keys[key_count % 16] = addr - AW'(applied_offset);
      key_count++;
    end
    send(ACT_FILL, addr);
  endtask

  task automatic hit();
    @(negedge clk);
    send(ACT_TRAIN, recent_key() + AW'(next_candidate));
  endtask

  task automatic gen_item(logic [OFF_W-1:0] favorite);
    int            pick;
    logic [AW-1:0] addr;
    @(negedge clk);
    pick = $urandom_range(0, 99);
    if (pick < 35) begin
      fill(rand_addr());
    end else if (pick < 85 && key_count > 0) begin
      addr = recent_key() + AW'(next_candidate);
      if (next_candidate != favorite && $urandom_range(0, 1)) begin
        addr = addr + AW'($urandom_range(1, 9));
      end
      send(ACT_TRAIN, addr);
    end else begin
      send(ACT_TRAIN, rand_addr());
    end
  endtask

  task automatic hold_off();
    int n;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 65) n = 0;
    else if (pick < 95) n = $urandom_range(1, 3);
    else n = $urandom_range(10, 40);
    if (gaps_on && n > 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (6) @(negedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_phase(logic [CFG_DATA_W-1:0] score, logic [CFG_DATA_W-1:0] rounds,
                           logic [CFG_DATA_W-1:0] bad, int count, bit gaps);
    logic [OFF_W-1:0] favorite;
    write_reg(REG_SCORE_LIMIT, score);
    write_reg(REG_ROUND_LIMIT, rounds);
    write_reg(REG_BAD_SCORE, bad);
    gaps_on = gaps;
    @(negedge clk);
    favorite = next_candidate;
    repeat (count) begin
      hold_off();
      gen_item(favorite);
    end
    drain();
  endtask

  initial begin
    rst = 1'b1;
    start = 1'b0;
    action = ACT_TRAIN;
    access_addr = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_SCORE_LIMIT;
    cfg_data = '0;
    key_count = 0;
    gaps_on = 1'b0;
    repeat (12) @(negedge clk);
    rst <= 1'b0;

    // An address equal to the first candidate matches a table entry never written.
    @(negedge clk) send(ACT_TRAIN, AW'(2));
    @(negedge clk) send(ACT_TRAIN, '0);
    @(negedge clk) send(ACT_TRAIN, '1);
    @(negedge clk) fill('1);
    @(negedge clk) fill('0);
    @(negedge clk) fill(48'h8000_0000_0001);
    hit();
    @(negedge clk) fill(48'hABCD_EF01_2345);
    hit();
    hit();
    @(negedge clk) send(ACT_FILL, 48'h7FFF_FFFF_FFC0);
    @(negedge clk) send(ACT_TRAIN, 48'hFFFF_FFFF_FFC0);
    drain();

    run_phase(8'd0, 8'd1, 8'd0, 60, 1'b1);
    run_phase(8'd31, 8'd0, 8'd1, 60, 1'b0);
    run_phase(8'd3, 8'd1, 8'd0, 250, 1'b1);
    run_phase(8'd255, 8'd255, 8'd0, 250, 1'b1);
    run_phase(8'd255, 8'd1, 8'd255, 150, 1'b1);
    run_phase(8'd1, 8'd2, 8'd0, 200, 1'b0);
    run_phase(8'd6, 8'd3, 8'd2, 380, 1'b1);
    run_phase(8'd31, 8'd100, 8'd1, 250, 1'b1);

    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/bopl_pkg.sv
rtl/bopl_rr_table.sv
rtl/bopl_score_table.sv
rtl/bopl_learner.sv
rtl/best_offset_prefetch_learner.sv
tb/bopl_prefetch_checker.sv
tb/testbench.sv
